@@ rtl/pcdc_pkg.sv @@
package pcdc_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ARG    = 2'd1,
        ST_BAD_HANDLE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PATH_WHOLE = 2'd0,
        PATH_LAYER = 2'd1,
        PATH_SLICE = 2'd2,
        PATH_ROW   = 2'd3
    } path_t;

    // Register index, taken from paddr[4:3] (64-bit registers at 8*i)
    typedef enum logic [1:0] {
        REG_SRC_BYTES = 2'd0,
        REG_DST_BYTES = 2'd1,
        REG_SRC_BOUND = 2'd2,
        REG_DST_BOUND = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] src_start;
        logic [63:0] dst_start;
        logic [63:0] src_row_stride;
        logic [63:0] dst_row_stride;
        logic [63:0] src_slice_stride;
        logic [63:0] dst_slice_stride;
        logic [63:0] src_layer_stride;
        logic [63:0] dst_layer_stride;
        logic [63:0] row_bytes;
        logic [31:0] rows;
        logic [31:0] slices;
        logic [31:0] layers;
    } desc_t;

    typedef struct packed {
        status_t     status;
        path_t       copy_path;
        logic [63:0] chunk_bytes;
        logic [63:0] src_extent;
        logic [63:0] dst_extent;
    } verdict_t;

    // Partial products of a 64x32 multiply, one 32x32 multiply each
    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } pp_t;

    function automatic pp_t mul_split(input logic [63:0] a, input logic [31:0] b);
        pp_t pp;
        begin
            pp.hi = {32'd0, a[63:32]} * {32'd0, b};
            pp.lo = {32'd0, a[31:0]} * {32'd0, b};
            mul_split = pp;
        end
    endfunction

    // Join the halves: 64-bit product with overflow flag on top
    function automatic logic [64:0] mul_join(input pp_t pp);
        logic [95:0] p;
        begin
            p = {pp.hi, 32'd0} + {32'd0, pp.lo};
            mul_join = {(p[95:64] != 32'd0), p[63:0]};
        end
    endfunction

endpackage

@@ rtl/pcdc_if.sv @@
interface pcdc_desc_if;
    logic           valid;
    logic           ready;
    pcdc_pkg::desc_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcdc_verdict_if;
    logic              valid;
    logic              ready;
    pcdc_pkg::verdict_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/pitched_copy_descriptor_checker_unit.sv @@
// Pitched 3D copy descriptor checker. One descriptor word in, one verdict word
// out; a new descriptor may enter every cycle while the pipe is not stalled. The
// six-stage pipeline holds, in order: 32x32 partial products, product join,
// span sums with slice-size partials, bounds compares with layer-size join and
// row and slice contiguity, layer contiguity with total partials, total join and
// verdict select. The whole pipe advances when the output stage is empty or
// being taken, so a stall holds every stage in place. Configuration registers
// sit on an APB port at byte addresses 0, 8, 16, 24 (64-bit data); write them
// only while idle.
module pitched_copy_descriptor_checker_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [63:0]              pwdata,
    output logic [63:0]              prdata,
    output logic                     pready,
    pcdc_desc_if.sink                desc,
    pcdc_verdict_if.source           verdict
);
    import pcdc_pkg::*;

    localparam int Stages = 6;

    logic [63:0] src_buf_reg, dst_buf_reg;
    logic        src_bound_reg, dst_bound_reg;
    logic        wr;
    reg_idx_t    reg_idx;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            src_buf_reg   <= '0;
            dst_buf_reg   <= '0;
            src_bound_reg <= 1'b0;
            dst_bound_reg <= 1'b0;
        end else if (wr) begin
            unique case (reg_idx)
                REG_SRC_BYTES: src_buf_reg <= pwdata;
                REG_DST_BYTES: dst_buf_reg <= pwdata;
                REG_SRC_BOUND: src_bound_reg <= pwdata[0];
                REG_DST_BOUND: dst_bound_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SRC_BYTES: prdata = src_buf_reg;
            REG_DST_BYTES: prdata = dst_buf_reg;
            REG_SRC_BOUND: prdata = {63'd0, src_bound_reg};
            REG_DST_BOUND: prdata = {63'd0, dst_bound_reg};
            default: prdata = '0;
        endcase
    end

    // Global advance: every stage moves together.
    logic adv;
    logic [Stages-1:0] v_reg;
    assign adv = !v_reg[Stages-1] || verdict.ready;
    assign desc.ready = adv;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[Stages-2:0], desc.valid};
    end

    // ---- stage 1: partial products of the per-axis terms, simple checks
    desc_t       d1_reg;
    pp_t         sr1_reg, dr1_reg, ss1_reg, ds1_reg, sl1_reg, dl1_reg, rbn1_reg;
    logic        zero1_reg, short1_reg;
    logic        nr_gt1, ns_gt1, nl_gt1;
    logic [31:0] nr_m1, ns_m1, nl_m1;
    desc_t       di;
    assign di = desc.data;
    assign nr_gt1 = di.rows > 32'd1;
    assign ns_gt1 = di.slices > 32'd1;
    assign nl_gt1 = di.layers > 32'd1;
    // a count of 0 or 1 adds nothing to the span
    assign nr_m1 = nr_gt1 ? di.rows - 32'd1 : 32'd0;
    assign ns_m1 = ns_gt1 ? di.slices - 32'd1 : 32'd0;
    assign nl_m1 = nl_gt1 ? di.layers - 32'd1 : 32'd0;

    always_ff @(posedge clk) begin
        if (adv) begin
            d1_reg   <= di;
            sr1_reg  <= mul_split(di.src_row_stride, nr_m1);
            dr1_reg  <= mul_split(di.dst_row_stride, nr_m1);
            ss1_reg  <= mul_split(di.src_slice_stride, ns_m1);
            ds1_reg  <= mul_split(di.dst_slice_stride, ns_m1);
            sl1_reg  <= mul_split(di.src_layer_stride, nl_m1);
            dl1_reg  <= mul_split(di.dst_layer_stride, nl_m1);
            rbn1_reg <= mul_split(di.row_bytes, di.rows);
            zero1_reg <= di.row_bytes == 64'd0 || di.rows == 32'd0 ||
                         di.slices == 32'd0 || di.layers == 32'd0;
            short1_reg <= nr_gt1 && (di.src_row_stride < di.row_bytes ||
                                     di.dst_row_stride < di.row_bytes);
        end
    end

    // ---- stage 2: join the partial products
    desc_t       d2_reg;
    logic [64:0] sr2_reg, dr2_reg, ss2_reg, ds2_reg, sl2_reg, dl2_reg, rbn2_reg;
    logic        bad2_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            d2_reg   <= d1_reg;
            sr2_reg  <= mul_join(sr1_reg);
            dr2_reg  <= mul_join(dr1_reg);
            ss2_reg  <= mul_join(ss1_reg);
            ds2_reg  <= mul_join(ds1_reg);
            sl2_reg  <= mul_join(sl1_reg);
            dl2_reg  <= mul_join(dl1_reg);
            rbn2_reg <= mul_join(rbn1_reg);
            bad2_reg <= zero1_reg || short1_reg;
        end
    end

    // ---- stage 3: span sums, slice size times slices (partials)
    desc_t       d3_reg;
    logic [63:0] sspan3_reg, dspan3_reg, rbn3_reg;
    logic        sov3_reg, dov3_reg, rbnov3_reg, bad3_reg;
    pp_t         laypp3_reg;
    logic [65:0] s_a, d_a;
    logic [66:0] s_b, d_b;

    always_comb begin
        s_a = {1'b0, sr2_reg} + {1'b0, ss2_reg};
        s_b = {1'b0, s_a} + {2'b0, sl2_reg} + {3'b0, d2_reg.row_bytes};
        d_a = {1'b0, dr2_reg} + {1'b0, ds2_reg};
        d_b = {1'b0, d_a} + {2'b0, dl2_reg} + {3'b0, d2_reg.row_bytes};
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            d3_reg     <= d2_reg;
            sspan3_reg <= s_b[63:0];
            dspan3_reg <= d_b[63:0];
            sov3_reg   <= sr2_reg[64] || ss2_reg[64] || sl2_reg[64] || (s_b[66:64] != 3'd0);
            dov3_reg   <= dr2_reg[64] || ds2_reg[64] || dl2_reg[64] || (d_b[66:64] != 3'd0);
            rbn3_reg   <= rbn2_reg[63:0];
            rbnov3_reg <= rbn2_reg[64];
            laypp3_reg <= mul_split(rbn2_reg[63:0], d2_reg.slices);
            bad3_reg   <= bad2_reg;
        end
    end

    // ---- stage 4: buffer fit, layer size join, row and slice contiguity
    desc_t       d4_reg;
    logic [63:0] sspan4_reg, dspan4_reg, rbn4_reg, lay4_reg;
    logic        arg4_reg, rbnov4_reg, layov4_reg, rows_c4_reg, sl_c4_reg;
    logic        sfit, dfit, rows_c, sl_c;
    logic [64:0] lay_p;

    always_comb begin
        sfit = (d3_reg.src_start <= src_buf_reg) &&
               (sspan3_reg <= src_buf_reg - d3_reg.src_start);
        dfit = (d3_reg.dst_start <= dst_buf_reg) &&
               (dspan3_reg <= dst_buf_reg - d3_reg.dst_start);
        lay_p = mul_join(laypp3_reg);
        rows_c = d3_reg.rows <= 32'd1 || (d3_reg.src_row_stride == d3_reg.row_bytes &&
                                          d3_reg.dst_row_stride == d3_reg.row_bytes);
        sl_c = rows_c && (d3_reg.slices <= 32'd1 ||
               (!rbnov3_reg && d3_reg.src_slice_stride == rbn3_reg &&
                d3_reg.dst_slice_stride == rbn3_reg));
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            d4_reg      <= d3_reg;
            sspan4_reg  <= sspan3_reg;
            dspan4_reg  <= dspan3_reg;
            rbn4_reg    <= rbn3_reg;
            lay4_reg    <= lay_p[63:0];
            rbnov4_reg  <= rbnov3_reg;
            layov4_reg  <= rbnov3_reg || lay_p[64];
            arg4_reg    <= bad3_reg || sov3_reg || dov3_reg || !sfit || !dfit;
            rows_c4_reg <= rows_c;
            sl_c4_reg   <= sl_c;
        end
    end

    // ---- stage 5: layer contiguity, total = layer size times layers (partials)
    logic [63:0] sspan5_reg, dspan5_reg, rbn5_reg, lay5_reg, rb5_reg;
    pp_t         totpp5_reg;
    logic        arg5_reg, rbnov5_reg, layov5_reg, rows_c5_reg, sl_c5_reg, ly_c5_reg;
    logic        hnd5_reg;
    logic        ly_c;

    always_comb begin
        ly_c = sl_c4_reg && (d4_reg.layers <= 32'd1 ||
               (!layov4_reg && d4_reg.src_layer_stride == lay4_reg &&
                d4_reg.dst_layer_stride == lay4_reg));
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            sspan5_reg  <= sspan4_reg;
            dspan5_reg  <= dspan4_reg;
            rbn5_reg    <= rbn4_reg;
            lay5_reg    <= lay4_reg;
            rb5_reg     <= d4_reg.row_bytes;
            totpp5_reg  <= mul_split(lay4_reg, d4_reg.layers);
            arg5_reg    <= arg4_reg;
            rbnov5_reg  <= rbnov4_reg;
            layov5_reg  <= layov4_reg;
            rows_c5_reg <= rows_c4_reg;
            sl_c5_reg   <= sl_c4_reg;
            ly_c5_reg   <= ly_c;
            hnd5_reg    <= !src_bound_reg || !dst_bound_reg;
        end
    end

    // ---- stage 6: total join, verdict
    verdict_t    out_reg, out_next;
    logic        tight_bad;
    logic [64:0] tot_p;

    always_comb begin
        out_next  = '0;
        tight_bad = 1'b0;
        tot_p     = mul_join(totpp5_reg);
        if (ly_c5_reg) begin
            out_next.copy_path   = PATH_WHOLE;
            out_next.chunk_bytes = tot_p[63:0];
            tight_bad = layov5_reg || tot_p[64];
        end else if (sl_c5_reg) begin
            out_next.copy_path   = PATH_LAYER;
            out_next.chunk_bytes = lay5_reg;
            tight_bad = layov5_reg;
        end else if (rows_c5_reg) begin
            out_next.copy_path   = PATH_SLICE;
            out_next.chunk_bytes = rbn5_reg;
            tight_bad = rbnov5_reg;
        end else begin
            out_next.copy_path   = PATH_ROW;
            out_next.chunk_bytes = rb5_reg;
        end
        out_next.src_extent = sspan5_reg;
        out_next.dst_extent = dspan5_reg;
        out_next.status     = ST_OK;
        if (hnd5_reg) begin
            out_next = '0;
            out_next.status = ST_BAD_HANDLE;
        end else if (arg5_reg || tight_bad) begin
            out_next = '0;
            out_next.status = ST_BAD_ARG;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) out_reg <= out_next;
    end

    assign verdict.valid = v_reg[Stages-1];
    assign verdict.data  = out_reg;

endmodule

@@ rtl/pcdc_checker.sv @@
module pcdc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input pcdc_pkg::verdict_t  out_data
);
    import pcdc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("verdict changed under stall");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
        out_data.chunk_bytes == 64'd0 && out_data.src_extent == 64'd0)
        else $error("error verdict carries payload");

    a_no_st3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_OK || out_data.status == ST_BAD_ARG ||
                       out_data.status == ST_BAD_HANDLE))
        else $error("bad status code");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // output only turns valid after the pipe has advanced
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("verdict from nothing");

endmodule

bind pitched_copy_descriptor_checker_unit pcdc_checker u_pcdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (desc.valid),
    .in_ready (desc.ready),
    .out_valid(verdict.valid),
    .out_ready(verdict.ready),
    .out_data (verdict.data)
);
